FILE: hdl/unsorted_table_with_cursor_macros.svh
// assertion macros shared by the checker of the unsorted table with cursor
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef UNSORTED_TABLE_WITH_CURSOR_MACROS_SVH
`define UNSORTED_TABLE_WITH_CURSOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define UTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table check failed");

// next-cycle implication, disabled while in reset
`define UTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table check failed");

`endif

FILE: hdl/utc_pkg.sv
// types, constants and helpers of the unsorted table with cursor
// no dependencies; used by every module of the block
`default_nettype none

package utc_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CUR_W  = 8;
    localparam int DATA_W = 16;
    localparam int KIND_W = 4;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > CUR_W - 1) ? CNT_W : CUR_W - 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 4'd0,
        KIND_FIND    = 4'd1,
        KIND_DELETE  = 4'd2,
        KIND_READ    = 4'd3,
        KIND_WRITE   = 4'd4,
        KIND_SET     = 4'd5,
        KIND_ADVANCE = 4'd6,
        KIND_RESET   = 4'd7,
        KIND_CLEAR   = 4'd8
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_BADCUR = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] page;
        logic [DATA_W-1:0] position;
    } entry_t;

    // first field in the highest bits
    typedef struct packed {
        logic signed [CUR_W-1:0] new_cursor;
        logic [DATA_W-1:0]       entry_position;
        logic [DATA_W-1:0]       entry_page;
    } in_data_t;

    typedef struct packed {
        logic [DATA_W-1:0]       read_position;
        logic [DATA_W-1:0]       read_page;
        logic                    is_full;
        logic                    is_empty;
        logic [CNT_W-1:0]        entry_count;
        logic                    cursor_valid;
        logic signed [CUR_W-1:0] cursor;
        logic                    found;
        status_t                 status;
    } result_t;

    localparam int IN_W      = $bits(in_data_t);
    localparam int RES_W     = $bits(result_t);
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // cursor lies in 0 .. count-1
    function automatic logic cur_ok(input logic signed [CUR_W-1:0] cur,
                                    input logic [CNT_W-1:0] cnt);
        return !cur[CUR_W-1] && (CMP_W'(cur[CUR_W-2:0]) < CMP_W'(cnt));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/utc_cell.sv
// one storage cell of the entry ring: holds an entry, takes its neighbour's on shift
// depends on utc_pkg
`default_nettype none

module utc_cell (
    input  wire logic           clk,
    input  wire logic           shift,
    input  utc_pkg::entry_t     d,
    output utc_pkg::entry_t     q
);

    utc_pkg::entry_t entry_reg;
    utc_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = shift ? d : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

FILE: hdl/unsorted_table_with_cursor.sv
// top level of the unsorted table with cursor: control, cursor and count, ring of cells
// depends on utc_pkg and utc_cell
`default_nettype none

// the table holds up to DEPTH (page, position) entries in a ring of cells; cell 0
// is the head. every table operation that is not refused rotates the whole ring,
// one step a cycle, so that entry k passes the head at step k and the ring is back
// in place at the end: find compares the head with the key, read captures the
// head, insert and write replace the entry as it leaves the head. delete takes
// two turns, the first picks up the last entry, the second drops it into the
// slot at the cursor. an item that rotates the ring goes from the walk state to
// the finish state; cursor operations, clear and refused items (insert into a
// full table, cursor not valid) go from acceptance straight to the finish state.
// the finish state writes the result register and frees the input together. a
// result still held in the output register by the receiver stalls the next item
// in the finish state. one item is in work at a time; a new item is taken when
// the last has left the control, even while its result still waits in the output
// register. the ring needs no clearing pass: only slots below the count are ever
// read.
module unsorted_table_with_cursor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [utc_pkg::KIND_W-1:0]     s_tuser,   // kind
    input  wire logic [utc_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_page, entry_position, new_cursor
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status, found, cursor, cursor_valid, entry_count, is_empty, is_full,
    // read_page, read_position, zero fill
    output logic [utc_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int DEPTH  = utc_pkg::DEPTH;
    localparam int ADDR_W = utc_pkg::ADDR_W;
    localparam int CNT_W  = utc_pkg::CNT_W;
    localparam int CUR_W  = utc_pkg::CUR_W;
    localparam int CMP_W  = utc_pkg::CMP_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                  state_reg;
    utc_pkg::kind_t          kind_reg;
    utc_pkg::in_data_t       item_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [CUR_W-1:0] cursor_reg;
    logic [ADDR_W-1:0]       step_reg;
    logic                    lap_reg;
    logic                    hit_reg;
    logic [ADDR_W-1:0]       hit_idx_reg;
    utc_pkg::entry_t         cap_reg;
    logic                    m_valid_reg;
    utc_pkg::result_t        m_data_reg;

    utc_pkg::in_data_t       s_item;
    utc_pkg::kind_t          s_kind;
    logic                    accept;
    logic                    table_full;
    logic                    cursor_ok;
    logic                    need_walk;

    utc_pkg::entry_t         ring_q [DEPTH];
    utc_pkg::entry_t         tail_in;
    utc_pkg::entry_t         key;
    logic                    shift;
    logic                    last_step;
    logic                    walk_done;
    logic                    at_cursor;
    logic                    at_count;
    logic                    at_last;
    logic                    head_match;

    logic                    fin_ready;
    logic                    fin_fire;
    logic [CNT_W-1:0]        count_next;
    logic signed [CUR_W-1:0] cursor_next;
    utc_pkg::result_t        res_next;

    assign s_item = utc_pkg::in_data_t'(s_tdata[utc_pkg::IN_W-1:0]);
    assign s_kind = utc_pkg::kind_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign table_full = (count_reg == CNT_W'(DEPTH));
    assign cursor_ok  = utc_pkg::cur_ok(cursor_reg, count_reg);

    // which items rotate the ring; refused ones go straight to the result
    always_comb
    begin
        unique case (s_kind)
            utc_pkg::KIND_INSERT: need_walk = !table_full;
            utc_pkg::KIND_FIND:   need_walk = 1'b1;
            utc_pkg::KIND_DELETE,
            utc_pkg::KIND_READ,
            utc_pkg::KIND_WRITE:  need_walk = cursor_ok;
            default:              need_walk = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- ring
    assign shift = (state_reg == ST_WALK);
    assign key   = '{page: item_reg.entry_page, position: item_reg.entry_position};

    assign last_step  = (step_reg == ADDR_W'(DEPTH - 1));
    assign walk_done  = last_step && ((kind_reg != utc_pkg::KIND_DELETE) || lap_reg);
    assign at_cursor  = (CMP_W'(cursor_reg[CUR_W-2:0]) == CMP_W'(step_reg));
    assign at_count   = (CNT_W'(step_reg) == count_reg);
    assign at_last    = (CNT_W'(step_reg) == count_reg - CNT_W'(1));
    assign head_match = (ring_q[0] == key) && (CNT_W'(step_reg) < count_reg);

    // what re-enters the ring at the tail as the head entry leaves
    always_comb
    begin
        tail_in = ring_q[0];
        unique case (kind_reg)
            utc_pkg::KIND_INSERT:
            begin
                if (at_count)
                    tail_in = key;
            end
            utc_pkg::KIND_WRITE:
            begin
                if (at_cursor)
                    tail_in = key;
            end
            utc_pkg::KIND_DELETE:
            begin
                if (lap_reg && at_cursor)
                    tail_in = cap_reg;
            end
            default:
            begin
                tail_in = ring_q[0];
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            utc_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (tail_in),
                .q     (ring_q[i])
            );
        end
        else
        begin : g_body
            utc_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (ring_q[i+1]),
                .q     (ring_q[i])
            );
        end
    end

    // ---------------------------------------------------------- finishing
    assign fin_ready = !m_valid_reg || m_tready;
    assign fin_fire  = (state_reg == ST_FINISH) && fin_ready;

    always_comb
    begin
        count_next         = count_reg;
        cursor_next        = cursor_reg;
        res_next           = '0;
        res_next.status    = utc_pkg::STATUS_OK;
        unique case (kind_reg)
            utc_pkg::KIND_INSERT:
            begin
                if (table_full)
                    res_next.status = utc_pkg::STATUS_FULL;
                else
                begin
                    cursor_next = CUR_W'(count_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            utc_pkg::KIND_FIND:
            begin
                // a miss leaves the cursor at the count
                res_next.found = hit_reg;
                cursor_next    = hit_reg ? CUR_W'(hit_idx_reg) : CUR_W'(count_reg);
            end
            utc_pkg::KIND_DELETE:
            begin
                if (!cursor_ok)
                    res_next.status = utc_pkg::STATUS_BADCUR;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            utc_pkg::KIND_READ:
            begin
                if (!cursor_ok)
                    res_next.status = utc_pkg::STATUS_BADCUR;
                else
                begin
                    res_next.read_page     = cap_reg.page;
                    res_next.read_position = cap_reg.position;
                end
            end
            utc_pkg::KIND_WRITE:
            begin
                if (!cursor_ok)
                    res_next.status = utc_pkg::STATUS_BADCUR;
            end
            utc_pkg::KIND_SET:
            begin
                cursor_next = item_reg.new_cursor;
            end
            utc_pkg::KIND_ADVANCE:
            begin
                cursor_next = cursor_reg + CUR_W'(1);
            end
            utc_pkg::KIND_RESET:
            begin
                cursor_next = '1;
            end
            utc_pkg::KIND_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        res_next.cursor       = cursor_next;
        res_next.cursor_valid = utc_pkg::cur_ok(cursor_next, count_next);
        res_next.entry_count  = count_next;
        res_next.is_empty     = (count_next == '0);
        res_next.is_full      = (count_next == CNT_W'(DEPTH));
    end

    // ------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '1;
            step_reg    <= '0;
            lap_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // a result taken while a new one is written keeps the register full
            if (m_valid_reg && m_tready && !fin_fire)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg  <= '0;
                        lap_reg   <= 1'b0;
                        hit_reg   <= 1'b0;
                        state_reg <= need_walk ? ST_WALK : ST_FINISH;
                    end
                end
                ST_WALK:
                begin
                    if (kind_reg == utc_pkg::KIND_FIND && head_match && !hit_reg)
                        hit_reg <= 1'b1;
                    if (last_step)
                    begin
                        step_reg <= '0;
                        lap_reg  <= 1'b1;
                    end
                    else
                        step_reg <= step_reg + ADDR_W'(1);
                    if (walk_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (fin_ready)
                    begin
                        count_reg   <= count_next;
                        cursor_reg  <= cursor_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_kind;
            item_reg <= s_item;
        end
        if (shift && kind_reg == utc_pkg::KIND_FIND && head_match && !hit_reg)
            hit_idx_reg <= step_reg;
        // read picks up the entry at the cursor, delete the last entry
        if (shift && !lap_reg)
        begin
            if ((kind_reg == utc_pkg::KIND_READ && at_cursor) ||
                (kind_reg == utc_pkg::KIND_DELETE && at_last))
                cap_reg <= ring_q[0];
        end
        if (fin_fire)
            m_data_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = utc_pkg::M_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire

FILE: hdl/utc_checker.sv
// port-level checks of the unsorted table with cursor, bound to the top level
// depends on utc_pkg and unsorted_table_with_cursor_macros.svh
`default_nettype none
`include "unsorted_table_with_cursor_macros.svh"

module utc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [utc_pkg::M_TDATA_W-1:0]  m_tdata
);

    utc_pkg::result_t res;

    assign res = utc_pkg::result_t'(m_tdata[utc_pkg::RES_W-1:0]);

    // a stalled result item holds
    `UTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one item in work at a time
    `UTC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // empty flag agrees with the count
    `UTC_ASSERT_SAME(a_empty, m_tvalid, res.is_empty == (res.entry_count == '0))

    // a refused insert only happens on a full table
    `UTC_ASSERT_SAME(a_full, m_tvalid && res.status == utc_pkg::STATUS_FULL, res.is_full)

    // a valid cursor is non-negative and the table is not empty
    `UTC_ASSERT_SAME(a_cur, m_tvalid && res.cursor_valid, !res.cursor[7] && !res.is_empty)

endmodule

bind unsorted_table_with_cursor utc_checker u_utc_checker (.*);

`default_nettype wire

FILE: tb/utc_table_check.sv
// result checker for the unsorted table with cursor: watches both item channels,
// keeps its own copy of the table and compares every result field by field
// depends on utc_pkg
`timescale 1ns / 1ps

module utc_table_check (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [utc_pkg::KIND_W-1:0]     s_tuser,   // kind
    input  wire logic [utc_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_page, entry_position, new_cursor
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // status, found, cursor, cursor_valid, entry_count, is_empty, is_full,
    // read_page, read_position, zero fill
    input  wire logic [utc_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                                  mismatch_count,
    output int                                  awaited_count
);

    import utc_pkg::*;

    // shadow of the table
    logic [DATA_W-1:0]       shadow_page [DEPTH];
    logic [DATA_W-1:0]       shadow_pos  [DEPTH];
    int                      shadow_count = 0;
    logic signed [CUR_W-1:0] shadow_cursor = -1;

    result_t awaited_results[$];

    function automatic logic shadow_cursor_ok();
        return (shadow_cursor >= 0) && (int'(shadow_cursor) < shadow_count);
    endfunction

    // applies one operation to the shadow table and returns the state it leaves
    task automatic predict_table_op(input logic [KIND_W-1:0] op, input in_data_t arg,
                                    output result_t res);
        int  slot;
        logic hit;
        res  = '0;
        hit  = 1'b0;
        slot = 0;
        case (op)
            KIND_INSERT:
                if (shadow_count >= DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    shadow_page[shadow_count] = arg.entry_page;
                    shadow_pos[shadow_count]  = arg.entry_position;
                    shadow_cursor = CUR_W'(shadow_count);
                    shadow_count++;
                end
            KIND_FIND:
            begin
                while (slot < shadow_count && !hit)
                begin
                    if (shadow_page[slot] == arg.entry_page &&
                        shadow_pos[slot] == arg.entry_position)
                        hit = 1'b1;
                    else
                        slot++;
                end
                // a miss leaves the cursor at the count
                shadow_cursor = CUR_W'(slot);
                res.found = hit;
            end
            KIND_DELETE:
                if (!shadow_cursor_ok())
                    res.status = STATUS_BADCUR;
                else
                begin
                    shadow_page[int'(shadow_cursor)] = shadow_page[shadow_count - 1];
                    shadow_pos[int'(shadow_cursor)]  = shadow_pos[shadow_count - 1];
                    shadow_count--;
                end
            KIND_READ:
                if (!shadow_cursor_ok())
                    res.status = STATUS_BADCUR;
                else
                begin
                    res.read_page     = shadow_page[int'(shadow_cursor)];
                    res.read_position = shadow_pos[int'(shadow_cursor)];
                end
            KIND_WRITE:
                if (!shadow_cursor_ok())
                    res.status = STATUS_BADCUR;
                else
                begin
                    shadow_page[int'(shadow_cursor)] = arg.entry_page;
                    shadow_pos[int'(shadow_cursor)]  = arg.entry_position;
                end
            KIND_SET:
                shadow_cursor = arg.new_cursor;
            KIND_ADVANCE:
                shadow_cursor = shadow_cursor + 1'b1;   // wraps within the cursor width
            KIND_RESET:
                shadow_cursor = -1;
            KIND_CLEAR:
            begin
                shadow_count  = 0;
                shadow_cursor = -1;
            end
            default:
                ;
        endcase
        res.cursor       = shadow_cursor;
        res.cursor_valid = shadow_cursor_ok();
        res.entry_count  = CNT_W'(shadow_count);
        res.is_empty     = (shadow_count == 0);
        res.is_full      = (shadow_count == DEPTH);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t seen;
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            shadow_count  = 0;
            shadow_cursor = -1;
            awaited_results.delete();
            awaited_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = result_t'(m_tdata[RES_W-1:0]);
                if (awaited_results.size() == 0)
                begin
                    $error("result item arrived with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("found", want.found, seen.found);
                    check_field("cursor", want.cursor, seen.cursor);
                    check_field("cursor_valid", want.cursor_valid, seen.cursor_valid);
                    check_field("entry_count", want.entry_count, seen.entry_count);
                    check_field("is_empty", want.is_empty, seen.is_empty);
                    check_field("is_full", want.is_full, seen.is_full);
                    check_field("read_page", want.read_page, seen.read_page);
                    check_field("read_position", want.read_position, seen.read_position);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_table_op(s_tuser, in_data_t'(s_tdata[IN_W-1:0]), fresh);
                awaited_results.push_back(fresh);
            end
            awaited_count = awaited_results.size();
        end
    end

endmodule

FILE: tb/tb.sv
// top of the testbench for the unsorted table with cursor: clock, reset, item
// stimulus and result back-pressure, verdict
// depends on utc_pkg, unsorted_table_with_cursor and utc_table_check
`timescale 1ns / 1ps

module tb;

    import utc_pkg::*;

    localparam int ITEM_TOTAL  = 1300;
    localparam int CALM_TAIL   = 200;          // last items sent with no idling
    localparam int HOLD_CYCLES = 400;          // long receiver hold-off
    localparam int DRAIN_WAIT  = 2 * DEPTH + 10;
    localparam int CYCLE_LIMIT = 1000000;

    // kinds the block does not know, from just above clear to the top code
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_CLEAR + 1'b1;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KIND_W-1:0]      s_tuser  = '0;   // kind
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // entry_page, entry_position, new_cursor
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // status, found, cursor, cursor_valid, entry_count, is_empty, is_full,
    // read_page, read_position, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;

    int  mismatch_count;
    int  awaited_count;
    int  sent_items  = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;   // no idling on either side while set, but for the one long hold-off
    bit  held_off    = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    unsorted_table_with_cursor uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    utc_table_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tuser        (s_tuser),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // mostly a tiny key space so that finds hit, sometimes any word
    function automatic logic [DATA_W-1:0] pick_word();
        if ($urandom_range(0, 3) == 0)
            return DATA_W'($urandom);
        return DATA_W'($urandom_range(0, 3));
    endfunction

    // cursor values from unset to one past the table
    function automatic logic signed [CUR_W-1:0] pick_cursor();
        return CUR_W'(int'($urandom_range(0, DEPTH + 1)) - 1);
    endfunction

    // offers one item, with an optional idle burst first, and waits for its handshake
    task automatic offer(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] pg,
                         input logic [DATA_W-1:0] ps, input logic signed [CUR_W-1:0] nc);
        in_data_t item;
        item.entry_page     = pg;
        item.entry_position = ps;
        item.new_cursor     = nc;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'(item);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    // shorthand for items whose operands are chosen at random
    task automatic offer_op(input logic [KIND_W-1:0] op);
        offer(op, pick_word(), pick_word(), pick_cursor());
    endtask

    // result side: random ready bursts, one long hold-off half way through
    initial
    begin : receiver
        wait (rst_n);
        forever
        begin
            if (!held_off && sent_items >= ITEM_TOTAL / 2)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // safety net against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: cursor unset, every cursor operation refused
        offer(KIND_READ, '0, '0, '0);
        offer(KIND_DELETE, '0, '0, '0);
        offer(KIND_WRITE, '1, '1, '1);
        offer(KIND_FIND, '0, '0, '0);              // miss on empty table
        // extremes of the entry fields
        offer(KIND_INSERT, '0, '0, '0);
        offer(KIND_INSERT, '1, '1, '1);
        offer(KIND_INSERT, 16'h5555, 16'hAAAA, 8'sh40);
        offer(KIND_FIND, '1, '1, '0);              // hit in the middle
        offer(KIND_READ, '0, '0, '0);
        offer(KIND_WRITE, 16'hAAAA, 16'h5555, '0);
        offer(KIND_READ, '0, '0, '0);
        offer(KIND_FIND, 16'h1234, '0, '0);        // miss leaves the cursor at the count
        offer(KIND_READ, '0, '0, '0);
        offer(KIND_SET, '0, '0, '0);
        offer(KIND_DELETE, '0, '0, '0);            // last entry moves into slot zero
        offer(KIND_READ, '0, '0, '0);
        offer(KIND_SET, '0, '0, -8'sd1);
        offer(KIND_SET, '0, '0, CUR_W'(DEPTH));
        offer(KIND_ADVANCE, '0, '0, '0);
        offer(KIND_RESET, '0, '0, '0);
        offer(KIND_SPARE_LO, '1, '1, '1);          // unknown kinds change nothing
        offer(KIND_SPARE_HI, '0, '0, '0);
        offer(KIND_CLEAR, '0, '0, '0);
        offer(KIND_READ, '0, '0, '0);

        // fill to the brim, then one insert too many
        repeat (DEPTH + 1)
            offer_op(KIND_INSERT);
        // walk the cursor past the top of its range
        offer(KIND_SET, '0, '0, CUR_W'(DEPTH));
        repeat (DEPTH + 2)
            offer_op(KIND_ADVANCE);
        offer(KIND_CLEAR, '0, '0, '0);

        while (sent_items < ITEM_TOTAL)
        begin
            calm = (sent_items >= ITEM_TOTAL - CALM_TAIL) || ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // fill: inserts, often read back at once
                    n = $urandom_range(4, DEPTH + 4);
                    repeat (n)
                    begin
                        offer_op(KIND_INSERT);
                        if ($urandom_range(0, 3) == 0)
                            offer_op(KIND_READ);
                    end
                end
                2, 3:
                begin
                    // search, then act on wherever the cursor landed
                    repeat ($urandom_range(4, 16))
                    begin
                        offer_op(KIND_FIND);
                        case ($urandom_range(0, 3))
                            0: offer_op(KIND_DELETE);
                            1: offer_op(KIND_READ);
                            2: offer_op(KIND_WRITE);
                            default: ;
                        endcase
                    end
                end
                4:
                begin
                    // drain from slot zero, running on into an empty table
                    offer(KIND_SET, pick_word(), pick_word(), '0);
                    repeat ($urandom_range(4, DEPTH + 4))
                    begin
                        offer_op(KIND_DELETE);
                        if ($urandom_range(0, 4) == 0)
                            offer_op(KIND_READ);
                    end
                end
                5, 6:
                begin
                    // cursor moves mixed with cursor operations
                    offer(KIND_SET, pick_word(), pick_word(), pick_cursor());
                    repeat ($urandom_range(2, 10))
                    begin
                        case ($urandom_range(0, 5))
                            0: offer_op(KIND_ADVANCE);
                            1: offer_op(KIND_READ);
                            2: offer_op(KIND_WRITE);
                            3: offer_op(KIND_DELETE);
                            4: offer_op(KIND_RESET);
                            default: offer_op(KIND_SET);
                        endcase
                    end
                end
                7:
                    offer_op(KIND_CLEAR);
                default:
                begin
                    // noise: any kind, any operands
                    repeat ($urandom_range(2, 10))
                        offer(KIND_W'($urandom_range(KIND_INSERT, KIND_SPARE_HI)),
                              DATA_W'($urandom), DATA_W'($urandom), pick_cursor());
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: unsorted_table_with_cursor.f
+incdir+hdl
hdl/utc_pkg.sv
hdl/utc_cell.sv
hdl/unsorted_table_with_cursor.sv
hdl/utc_checker.sv
tb/utc_table_check.sv
tb/tb.sv
